FILE: design/lbtc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lbtc_pkg;

	localparam int ENTRIES     = 64;
	localparam int SLOT_W      = $clog2(ENTRIES);
	localparam int LINK_W      = SLOT_W + 1;
	localparam int COUNT_W     = LINK_W;
	localparam int MARGIN_ROWS = 4;
	localparam int WORD_BYTES  = 4;

	// The top bit of a link marks the end of the chain.
	localparam logic [LINK_W-1:0] NIL = LINK_W'(ENTRIES);

	localparam logic [1:0] FN_ACCESS      = 2'd0;
	localparam logic [1:0] FN_REMOVE_POLY = 2'd1;
	localparam logic [1:0] FN_REMOVE_TEX  = 2'd2;
	localparam logic [1:0] FN_CLEAR       = 2'd3;

	localparam logic REG_BUDGET = 1'b0;
	localparam logic REG_TEXEL  = 1'b1;

	typedef struct packed {
		logic [15:0] polygon;
		logic [15:0] texture;
		logic [1:0]  mip;
		logic [31:0] size;
		logic [31:0] frame;
	} ent_t;

	typedef struct packed {
		logic [LINK_W-1:0] newer;
		logic [LINK_W-1:0] older;
	} lnk_t;

endpackage
`default_nettype wire

FILE: design/lbtc_size.sv
`timescale 1ns / 1ps
`default_nettype none
module lbtc_size (
	input  wire logic        clk,
	input  wire logic [2:0]  texel_bytes,
	input  wire logic [12:0] tex_width,
	input  wire logic [12:0] tex_height,
	input  wire logic [1:0]  mip_level,
	input  wire logic [15:0] lightmap_words,
	output logic      [31:0] entry_bytes
);
	import lbtc_pkg::*;

	logic [12:0] cols;
	logic [13:0] rows;
	logic [26:0] area_s1;
	logic [2:0]  tb_s1;
	logic [15:0] lw_s1;
	logic [29:0] texels;
	logic [17:0] lw_bytes;

	always_comb begin
		cols = tex_width >> mip_level;
		rows = ((14'(tex_height) + ((14'd1 << mip_level) - 14'd1)) >> mip_level)
			+ 14'(2 * MARGIN_ROWS);
	end

	// Two registered multiplies; the operands are held for the whole item.
	always_ff @(posedge clk) begin
		area_s1 <= 27'(cols) * 27'(rows);
		tb_s1   <= texel_bytes;
		lw_s1   <= lightmap_words;
	end

	always_comb begin
		texels   = 30'(tb_s1) * 30'(area_s1);
		lw_bytes = 18'(lw_s1) * 18'(WORD_BYTES);
	end

	always_ff @(posedge clk) begin
		entry_bytes <= 32'(texels) + 32'(lw_bytes);
	end

endmodule
`default_nettype wire

FILE: design/lru_byte_budget_texture_cache.sv
// A clear (func 3) goes straight to the finish state, which raises done; other items scan the entry
// memory at one slot a cycle, then a hit that is not already the newest entry, an insert, each
// eviction and each removal relink the chain through the link memory port.
// Throughput: one item at a time; busy is low while done is high, so the next start can be
// taken at the edge that ends the result beat.
// Reset clears the valid bits, chain ends, totals and budget; texel_bytes resets to 1.
// Results cannot be stalled: each is shown for the single cycle that done is high.
`timescale 1ns / 1ps
`default_nettype none
module lru_byte_budget_texture_cache (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [31:0] cfg_data,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic [15:0] polygon_id,
	input  wire logic [15:0] texture_id,
	input  wire logic [1:0]  mip_level,
	input  wire logic [12:0] tex_width,
	input  wire logic [12:0] tex_height,
	input  wire logic [15:0] lightmap_words,
	input  wire logic [31:0] frame_number,
	output logic             done,
	output logic             hit,
	output logic [5:0]       slot,
	output logic [31:0]      entry_bytes,
	output logic [6:0]       evicted_count,
	output logic [31:0]      total_bytes,
	output logic [6:0]       entry_count
);
	import lbtc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SC_START, ST_SCAN, ST_SIZE, ST_EV_CHK, ST_EV_PICK,
		ST_UL_RD, ST_UL_A, ST_UL_B, ST_PF_A, ST_PF_B, ST_TOUCH, ST_FINISH
	} state_t;

	state_t state_q;

	logic [1:0]  func_q, mip_q;
	logic [15:0] poly_q, tex_q, lw_q;
	logic [12:0] w_q, h_q;
	logic [31:0] frame_q, budget_q;
	logic [2:0]  tb_q;

	logic [ENTRIES-1:0] valid_q;
	logic [LINK_W-1:0]  front_q, back_q, nw_q, od_q;
	logic [31:0]        bytes_q, size_q;
	logic [COUNT_W-1:0] count_q, evict_q, idx_q;
	logic [SLOT_W-1:0]  cmp_idx_s1, tgt_q, slot_q, free_slot, victim;
	logic [32:0]        tot_q;
	logic               hit_q, drop_q, full_done_q, done_q, key_hit;
	logic [31:0]        new_size;

	ent_t ent_mem [ENTRIES];
	lnk_t lnk_mem [ENTRIES];
	ent_t ent_rd, ent_wd;
	lnk_t lnk_rd, lnk_wd;
	logic [SLOT_W-1:0] ent_ra, ent_wa, lnk_ra, lnk_wa;
	logic ent_we_all, ent_we_frame, lnk_we_new, lnk_we_old;

	lbtc_size u_size (
		.clk            (clk),
		.texel_bytes    (tb_q),
		.tex_width      (w_q),
		.tex_height     (h_q),
		.mip_level      (mip_q),
		.lightmap_words (lw_q),
		.entry_bytes    (new_size)
	);

	always_comb begin
		free_slot = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_slot = SLOT_W'(i);
		end
	end

	always_comb begin
		if (func_q == FN_REMOVE_TEX) begin
			key_hit = valid_q[cmp_idx_s1] && ent_rd.mip == mip_q && ent_rd.texture == tex_q;
		end else begin
			key_hit = valid_q[cmp_idx_s1] && ent_rd.mip == mip_q && ent_rd.polygon == poly_q;
		end
		victim = (ent_rd.frame == frame_q) ? front_q[SLOT_W-1:0] : back_q[SLOT_W-1:0];
	end

	// Memory address and write control.
	always_comb begin
		ent_ra       = tgt_q;
		lnk_ra       = tgt_q;
		ent_wa       = tgt_q;
		lnk_wa       = tgt_q;
		ent_we_all   = 1'b0;
		ent_we_frame = 1'b0;
		lnk_we_new   = 1'b0;
		lnk_we_old   = 1'b0;
		ent_wd       = '{polygon: poly_q, texture: tex_q, mip: mip_q, size: size_q,
			frame: frame_q};
		lnk_wd       = '{newer: NIL, older: front_q};
		case (state_q)
			ST_SC_START: ent_ra = idx_q[SLOT_W-1:0];
			ST_SCAN:     ent_ra = cmp_idx_s1 + SLOT_W'(1);
			ST_EV_CHK:   ent_ra = back_q[SLOT_W-1:0];
			ST_UL_A: begin
				lnk_wa     = lnk_rd.newer[SLOT_W-1:0];
				lnk_wd     = '{newer: lnk_rd.newer, older: lnk_rd.older};
				lnk_we_old = !lnk_rd.newer[SLOT_W];
			end
			ST_UL_B: begin
				lnk_wa     = od_q[SLOT_W-1:0];
				lnk_wd     = '{newer: nw_q, older: od_q};
				lnk_we_new = !od_q[SLOT_W];
			end
			ST_PF_A: begin
				lnk_we_new   = 1'b1;
				lnk_we_old   = 1'b1;
				ent_we_all   = !hit_q;
				ent_we_frame = hit_q;
			end
			ST_PF_B: begin
				lnk_wa     = front_q[SLOT_W-1:0];
				lnk_wd     = '{newer: {1'b0, tgt_q}, older: front_q};
				lnk_we_new = !front_q[SLOT_W];
			end
			ST_TOUCH: ent_we_frame = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		ent_rd <= ent_mem[ent_ra];
		lnk_rd <= lnk_mem[lnk_ra];
		if (ent_we_all) begin
			ent_mem[ent_wa] <= ent_wd;
		end else if (ent_we_frame) begin
			ent_mem[ent_wa].frame <= ent_wd.frame;
		end
		if (lnk_we_new) lnk_mem[lnk_wa].newer <= lnk_wd.newer;
		if (lnk_we_old) lnk_mem[lnk_wa].older <= lnk_wd.older;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			front_q     <= NIL;
			back_q      <= NIL;
			bytes_q     <= '0;
			count_q     <= '0;
			budget_q    <= '0;
			tb_q        <= 3'd1;
			done_q      <= 1'b0;
			hit_q       <= 1'b0;
			drop_q      <= 1'b0;
			full_done_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					done_q <= 1'b0;
					if (cfg_we) begin
						case (cfg_idx)
							REG_BUDGET: begin
								budget_q <= cfg_data;
								valid_q  <= '0;
								front_q  <= NIL;
								back_q   <= NIL;
								bytes_q  <= '0;
								count_q  <= '0;
							end
							REG_TEXEL: tb_q <= cfg_data[2:0];
							default: ;
						endcase
					end
					if (start) begin
						func_q      <= func;
						poly_q      <= polygon_id;
						tex_q       <= texture_id;
						mip_q       <= mip_level;
						w_q         <= tex_width;
						h_q         <= tex_height;
						lw_q        <= lightmap_words;
						frame_q     <= frame_number;
						hit_q       <= 1'b0;
						slot_q      <= '0;
						size_q      <= '0;
						evict_q     <= (func == FN_CLEAR) ? count_q : '0;
						idx_q       <= '0;
						full_done_q <= 1'b0;
						if (func == FN_CLEAR) begin
							valid_q <= '0;
							front_q <= NIL;
							back_q  <= NIL;
							bytes_q <= '0;
							count_q <= '0;
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SC_START;
						end
					end
				end
				ST_SC_START: begin
					cmp_idx_s1 <= idx_q[SLOT_W-1:0];
					if (idx_q[SLOT_W]) begin
						state_q <= (func_q == FN_ACCESS) ? ST_SIZE : ST_FINISH;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (key_hit) begin
						tgt_q <= cmp_idx_s1;
						idx_q <= COUNT_W'(cmp_idx_s1) + COUNT_W'(1);
						case (func_q)
							FN_ACCESS: begin
								hit_q  <= 1'b1;
								slot_q <= cmp_idx_s1;
								size_q <= ent_rd.size;
								drop_q <= 1'b0;
								state_q <= (front_q == {1'b0, cmp_idx_s1}) ? ST_TOUCH : ST_UL_RD;
							end
							FN_REMOVE_POLY: begin
								hit_q   <= 1'b1;
								slot_q  <= cmp_idx_s1;
								drop_q  <= 1'b1;
								state_q <= ST_UL_RD;
							end
							default: begin
								drop_q  <= 1'b1;
								state_q <= ST_UL_RD;
							end
						endcase
					end else if (cmp_idx_s1 == SLOT_W'(ENTRIES - 1)) begin
						state_q <= (func_q == FN_ACCESS) ? ST_SIZE : ST_FINISH;
					end else begin
						cmp_idx_s1 <= cmp_idx_s1 + SLOT_W'(1);
					end
				end
				ST_SIZE: begin
					size_q  <= new_size;
					tot_q   <= {1'b0, bytes_q} + {1'b0, new_size};
					state_q <= ST_EV_CHK;
				end
				ST_EV_CHK: begin
					if (!back_q[SLOT_W] && tot_q > {1'b0, budget_q}) begin
						state_q <= ST_EV_PICK;
					end else if (!full_done_q && count_q[SLOT_W] && !back_q[SLOT_W]) begin
						// Every slot is taken: one more eviction by the same rule.
						full_done_q <= 1'b1;
						state_q     <= ST_EV_PICK;
					end else begin
						tgt_q   <= free_slot;
						slot_q  <= free_slot;
						state_q <= ST_PF_A;
					end
				end
				ST_EV_PICK: begin
					tgt_q   <= victim;
					drop_q  <= 1'b1;
					state_q <= ST_UL_RD;
				end
				ST_UL_RD: state_q <= ST_UL_A;
				ST_UL_A: begin
					nw_q <= lnk_rd.newer;
					od_q <= lnk_rd.older;
					if (lnk_rd.newer[SLOT_W]) front_q <= lnk_rd.older;
					if (drop_q) begin
						valid_q[tgt_q] <= 1'b0;
						if (count_q != '0) count_q <= count_q - COUNT_W'(1);
						evict_q <= evict_q + COUNT_W'(1);
						if (func_q == FN_ACCESS) begin
							tot_q <= tot_q - {1'b0, ent_rd.size};
						end else begin
							bytes_q <= bytes_q - ent_rd.size;
						end
						if (func_q == FN_REMOVE_POLY) size_q <= ent_rd.size;
					end
					state_q <= ST_UL_B;
				end
				ST_UL_B: begin
					if (od_q[SLOT_W]) back_q <= nw_q;
					if (!drop_q) begin
						state_q <= ST_PF_A;
					end else begin
						case (func_q)
							FN_ACCESS:      state_q <= ST_EV_CHK;
							FN_REMOVE_POLY: state_q <= ST_FINISH;
							default:        state_q <= ST_SC_START;
						endcase
					end
				end
				ST_PF_A: begin
					if (!hit_q) valid_q[tgt_q] <= 1'b1;
					state_q <= ST_PF_B;
				end
				ST_PF_B: begin
					if (front_q[SLOT_W]) back_q <= {1'b0, tgt_q};
					front_q <= {1'b0, tgt_q};
					if (!hit_q) begin
						count_q <= count_q + COUNT_W'(1);
						bytes_q <= tot_q[31:0];
					end
					state_q <= ST_FINISH;
				end
				ST_TOUCH: state_q <= ST_FINISH;
				ST_FINISH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign hit           = hit_q;
	assign slot          = slot_q;
	assign entry_bytes   = size_q;
	assign evicted_count = evict_q;
	assign total_bytes   = bytes_q;
	assign entry_count   = count_q;

endmodule
`default_nettype wire

FILE: design/lbtc_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module lbtc_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic       hit,
	input wire logic [6:0] evicted_count,
	input wire logic [6:0] entry_count
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result beat while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result beats back to back");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> entry_count <= 7'd64) else $error("entry count beyond table size");

	a_hit_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> evicted_count <= 7'd1) else $error("hit with several evictions");

endmodule

bind lru_byte_budget_texture_cache lbtc_chk u_lbtc_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.hit           (hit),
	.evicted_count (evicted_count),
	.entry_count   (entry_count)
);
`default_nettype wire

FILE: sim/lru_byte_budget_texture_cache_test.sv
`timescale 1ns / 1ps
module lru_byte_budget_texture_cache_test;
	import lbtc_pkg::*;

	localparam int NONE = ENTRIES;

	typedef struct {
		logic        hit;
		logic [5:0]  slot;
		logic [31:0] bytes;
		logic [6:0]  evicted;
		logic [31:0] total;
		logic [6:0]  count;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_idx = REG_BUDGET;
	logic [31:0] cfg_data = '0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  func = FN_ACCESS;
	logic [15:0] polygon_id = '0;
	logic [15:0] texture_id = '0;
	logic [1:0]  mip_level = '0;
	logic [12:0] tex_width = '0;
	logic [12:0] tex_height = '0;
	logic [15:0] lightmap_words = '0;
	logic [31:0] frame_number = '0;
	logic        done;
	logic        hit;
	logic [5:0]  slot;
	logic [31:0] entry_bytes;
	logic [6:0]  evicted_count;
	logic [31:0] total_bytes;
	logic [6:0]  entry_count;

	lru_byte_budget_texture_cache dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.start(start), .busy(busy), .func(func), .polygon_id(polygon_id),
		.texture_id(texture_id), .mip_level(mip_level), .tex_width(tex_width),
		.tex_height(tex_height), .lightmap_words(lightmap_words),
		.frame_number(frame_number), .done(done), .hit(hit), .slot(slot),
		.entry_bytes(entry_bytes), .evicted_count(evicted_count),
		.total_bytes(total_bytes), .entry_count(entry_count)
	);

	// Shadow copy of the cache table, its recency chain and its totals.
	bit          sh_valid [ENTRIES];
	logic [15:0] sh_poly [ENTRIES];
	logic [15:0] sh_tex [ENTRIES];
	logic [1:0]  sh_mip [ENTRIES];
	logic [31:0] sh_size [ENTRIES];
	logic [31:0] sh_frame [ENTRIES];
	int          sh_newer [ENTRIES];
	int          sh_older [ENTRIES];
	int          sh_front, sh_back, sh_count;
	logic [31:0] sh_bytes;
	logic [31:0] budget;
	logic [2:0]  texel;

	outcome_t    pending_outcomes[$];
	int          errors = 0;
	logic [31:0] frame_now = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic void empty_table();
		for (int i = 0; i < ENTRIES; i++) sh_valid[i] = 0;
		sh_front = NONE;
		sh_back = NONE;
		sh_bytes = 0;
		sh_count = 0;
	endfunction

	function automatic void unchain(int s);
		int nw, od;
		nw = sh_newer[s];
		od = sh_older[s];
		if (nw < ENTRIES) sh_older[nw] = od; else sh_front = od;
		if (od < ENTRIES) sh_newer[od] = nw; else sh_back = nw;
	endfunction

	function automatic void make_newest(int s);
		sh_newer[s] = NONE;
		sh_older[s] = sh_front;
		if (sh_front < ENTRIES) sh_newer[sh_front] = s; else sh_back = s;
		sh_front = s;
	endfunction

	function automatic logic [31:0] evict_slot(int s);
		unchain(s);
		sh_valid[s] = 0;
		if (sh_count > 0) sh_count--;
		return sh_size[s];
	endfunction

	function automatic int lookup(logic [15:0] p, logic [1:0] m);
		for (int i = 0; i < ENTRIES; i++)
			if (sh_valid[i] && sh_poly[i] == p && sh_mip[i] == m) return i;
		return -1;
	endfunction

	function automatic outcome_t cache_outcome(logic [1:0] f, logic [15:0] p, logic [15:0] t,
			logic [1:0] m, logic [12:0] w, logic [12:0] h, logic [15:0] lw, logic [31:0] fr);
		outcome_t o;
		int i, s, v;
		logic [63:0] cols, rows, sz, tot;
		o = '{hit: 0, slot: 0, bytes: 0, evicted: 0, total: 0, count: 0};
		i = lookup(p, m);
		case (f)
			FN_ACCESS: begin
				if (i >= 0) begin
					if (i != sh_front) begin
						unchain(i);
						make_newest(i);
					end
					sh_frame[i] = fr;
					o.hit = 1;
					o.slot = i[5:0];
					o.bytes = sh_size[i];
				end else begin
					cols = 64'(w >> m);
					rows = 64'((32'(h) + (32'd1 << m) - 32'd1) >> m) + 64'(2 * MARGIN_ROWS);
					sz = 64'(lw) * WORD_BYTES + 64'(texel) * cols * rows;
					tot = 64'(sh_bytes) + sz;
					// The victim is the oldest entry unless it was touched this frame.
					while (sh_back < ENTRIES && tot > 64'(budget)) begin
						v = sh_back;
						if (sh_frame[v] == fr) v = sh_front;
						tot -= 64'(evict_slot(v));
						o.evicted++;
					end
					if (sh_count >= ENTRIES && sh_back < ENTRIES) begin
						v = sh_back;
						if (sh_frame[v] == fr) v = sh_front;
						tot -= 64'(evict_slot(v));
						o.evicted++;
					end
					s = 0;
					for (int k = ENTRIES - 1; k >= 0; k--) if (!sh_valid[k]) s = k;
					sh_valid[s] = 1;
					sh_poly[s] = p;
					sh_tex[s] = t;
					sh_mip[s] = m;
					sh_size[s] = sz[31:0];
					sh_frame[s] = fr;
					make_newest(s);
					sh_count++;
					sh_bytes = tot[31:0];
					o.slot = s[5:0];
					o.bytes = sz[31:0];
				end
			end
			FN_REMOVE_POLY: begin
				if (i >= 0) begin
					o.bytes = evict_slot(i);
					sh_bytes -= o.bytes;
					o.hit = 1;
					o.slot = i[5:0];
					o.evicted = 1;
				end
			end
			FN_REMOVE_TEX: begin
				for (int k = 0; k < ENTRIES; k++)
					if (sh_valid[k] && sh_mip[k] == m && sh_tex[k] == t) begin
						sh_bytes -= evict_slot(k);
						o.evicted++;
					end
			end
			default: begin
				o.evicted = 7'(sh_count);
				empty_table();
			end
		endcase
		o.total = sh_bytes;
		o.count = 7'(sh_count);
		return o;
	endfunction

	function automatic void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Outputs are registered, so the falling edge sees them settled.
	always @(negedge clk) begin
		outcome_t e;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$error("result with no access outstanding");
				errors++;
			end else begin
				e = pending_outcomes.pop_front();
				compare("hit", 32'(e.hit), 32'(hit));
				compare("slot", 32'(e.slot), 32'(slot));
				compare("entry_bytes", e.bytes, entry_bytes);
				compare("evicted_count", 32'(e.evicted), 32'(evicted_count));
				compare("total_bytes", e.total, total_bytes);
				compare("entry_count", 32'(e.count), 32'(entry_count));
			end
		end
	end

	// Called at a rising edge; returns at the edge that took the beat, start still high.
	task automatic send_item(logic [1:0] f, logic [15:0] p, logic [15:0] t, logic [1:0] m,
			logic [12:0] w, logic [12:0] h, logic [15:0] lw, logic [31:0] fr);
		start <= 1'b1;
		func <= f;
		polygon_id <= p;
		texture_id <= t;
		mip_level <= m;
		tex_width <= w;
		tex_height <= h;
		lightmap_words <= lw;
		frame_number <= fr;
		do @(negedge clk); while (busy);
		@(posedge clk);
		pending_outcomes.push_back(cache_outcome(f, p, t, m, w, h, lw, fr));
	endtask

	task automatic pause_sender(int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BUDGET) begin
			empty_table();
			budget = value;
		end else begin
			texel = value[2:0];
		end
	endtask

	task automatic test_directed();
		write_reg(REG_BUDGET, 32'd5000);
		write_reg(REG_TEXEL, 32'd1);
		send_item(FN_ACCESS, 16'd1, 16'd7, 2'd0, 13'd16, 13'd16, 16'd0, 32'd1);
		send_item(FN_ACCESS, 16'd1, 16'd9, 2'd0, 13'd1, 13'd1, 16'd1, 32'd2);
		send_item(FN_ACCESS, 16'd2, 16'd7, 2'd3, 13'd1, 13'd1, 16'd0, 32'd2);
		send_item(FN_ACCESS, 16'd3, 16'd7, 2'd1, 13'd8191, 13'd8191, 16'hFFFF, 32'd2);
		send_item(FN_ACCESS, 16'd4, 16'd7, 2'd2, 13'd64, 13'd63, 16'd10, 32'd2);
		send_item(FN_ACCESS, 16'd5, 16'd8, 2'd0, 13'd32, 13'd32, 16'd5, 32'd2);
		send_item(FN_ACCESS, 16'd6, 16'd8, 2'd0, 13'd40, 13'd40, 16'd5, 32'd2);
		send_item(FN_ACCESS, 16'd6, 16'd8, 2'd1, 13'd40, 13'd40, 16'd5, 32'd3);
		send_item(FN_REMOVE_POLY, 16'd6, 16'd0, 2'd0, 13'd0, 13'd0, 16'd0, 32'd3);
		send_item(FN_REMOVE_POLY, 16'd6, 16'd0, 2'd0, 13'd0, 13'd0, 16'd0, 32'd3);
		send_item(FN_REMOVE_TEX, 16'd0, 16'd8, 2'd1, 13'd0, 13'd0, 16'd0, 32'd3);
		send_item(FN_REMOVE_TEX, 16'hFFFF, 16'hFFFF, 2'd3, 13'h1FFF, 13'h1FFF, 16'hFFFF,
			32'hFFFF_FFFF);
		send_item(FN_ACCESS, 16'hFFFF, 16'hFFFF, 2'd3, 13'h1FFF, 13'h1FFF, 16'hFFFF,
			32'hFFFF_FFFF);
		send_item(FN_CLEAR, 16'd0, 16'd0, 2'd0, 13'd0, 13'd0, 16'd0, 32'd0);
		send_item(FN_CLEAR, 16'd0, 16'd0, 2'd0, 13'd0, 13'd0, 16'd0, 32'd0);
		drain();
		write_reg(REG_BUDGET, 32'd0);
		write_reg(REG_TEXEL, 32'd7);
		send_item(FN_ACCESS, 16'd9, 16'd1, 2'd0, 13'd4, 13'd4, 16'd0, 32'd5);
		send_item(FN_ACCESS, 16'd10, 16'd1, 2'd0, 13'd4, 13'd4, 16'd0, 32'd5);
		drain();
	endtask

	task automatic test_random(logic [31:0] bud, logic [2:0] tb, int n, int idle_pct);
		logic [1:0]  f;
		logic [15:0] p, t, lw;
		logic [12:0] w, h;
		logic [31:0] fr;
		int r;
		write_reg(REG_BUDGET, bud);
		write_reg(REG_TEXEL, 32'(tb));
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			f = (r < 70) ? FN_ACCESS : (r < 85) ? FN_REMOVE_POLY : (r < 97) ? FN_REMOVE_TEX
				: FN_CLEAR;
			p = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
			t = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
			w = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(1, 64));
			h = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(1, 64));
			lw = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32));
			if ($urandom_range(7) == 0) frame_now++;
			fr = ($urandom_range(19) == 0) ? $urandom : frame_now;
			send_item(f, p, t, 2'($urandom_range(3)), w, h, lw, fr);
			pause_sender(idle_pct);
		end
		drain();
	endtask

	initial begin
		budget = 0;
		texel = 3'd1;
		empty_table();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(32'd20000, 3'd1, 130, 23);
		test_random(32'd200000, 3'd2, 130, 23);
		test_random(32'hFFFF_FFFF, 3'd4, 130, 74);
		test_random(32'd3000, 3'd3, 130, 74);
		test_random(32'd60000, 3'd7, 130, 0);
		test_random(32'd0, 3'd0, 40, 0);
		test_random(32'd100000, 3'd1, 110, 0);
		if (pending_outcomes.size() != 0) begin
			$error("%0d results never arrived", pending_outcomes.size());
			errors++;
		end
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
